@@ sv/ssrg_pkg.sv @@
// Shared types and constants for the sound shift register generator.
package ssrg_pkg;

    localparam int unsigned SHIFT_WIDTH     = 24;
    localparam int unsigned PHASE_WIDTH     = 25;
    localparam int unsigned COUNT_WIDTH     = 5;
    localparam int unsigned PERIOD_WIDTH    = 24;
    localparam int unsigned CFG_ADDR_WIDTH  = 2;
    localparam int unsigned CFG_DATA_WIDTH  = 24;
    localparam int unsigned S_TDATA_WIDTH   = 24;
    localparam int unsigned S_TUSER_WIDTH   = 2;
    localparam int unsigned M_TDATA_WIDTH   = 40;

    localparam int unsigned SHIFTS_PER_IRQ_DEFAULT = 24;

    localparam logic [PERIOD_WIDTH-1:0] FAST_PERIOD_RESET = 24'd1055623;
    localparam logic [PERIOD_WIDTH-1:0] SLOW_PERIOD_RESET = 24'd4222490;

    // One output sample in 9.16 phase units.
    localparam logic [PHASE_WIDTH-1:0] ONE_SAMPLE = 25'h001_0000;

    // Request kinds.
    localparam logic [1:0] REQ_TICK      = 2'd0;
    localparam logic [1:0] REQ_WRITE     = 2'd1;
    localparam logic [1:0] REQ_ACK       = 2'd2;

    // Register byte positions.
    localparam logic [1:0] SEL_BYTE0     = 2'd0;
    localparam logic [1:0] SEL_BYTE1     = 2'd1;
    localparam logic [1:0] SEL_BYTE2     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_FAST_PERIOD = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_SLOW_PERIOD = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_IRQ_ENABLE  = 2'd2;

    // Control byte bit positions.
    localparam int unsigned CTRL_NOISE  = 4;
    localparam int unsigned CTRL_FAST   = 5;
    localparam int unsigned CTRL_ENABLE = 7;

    // Noise mode tap and feedback target.
    localparam int unsigned NOISE_TAP   = 5;
    localparam int unsigned NOISE_DEST  = 15;

    typedef struct packed {
        logic [SHIFT_WIDTH-1:0] shift_data;
        logic [PHASE_WIDTH-1:0] phase;
        logic [COUNT_WIDTH-1:0] shift_count;
        logic                   irq_pending;
    } ssrg_state_t;

    typedef struct packed {
        logic [PERIOD_WIDTH-1:0] fast_period;
        logic [PERIOD_WIDTH-1:0] slow_period;
        logic                    irq_enable;
    } ssrg_cfg_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] line_control;
        logic [1:0] byte_select;
        logic [7:0] byte_value;
    } ssrg_req_t;

    typedef struct packed {
        logic [7:0]             sample_level;
        logic                   irq_raised;
        logic                   irq_pending_now;
        logic [SHIFT_WIDTH-1:0] shift_contents;
    } ssrg_result_t;

endpackage

@@ sv/sound_shift_register_generator_unit.sv @@
// Top level of the sound shift register generator: stream ports, state and result register.
//
// This block models a video-chip sound generator built around a 24-bit shift
// register that is clocked by a 9.16 fixed-point phase accumulator. Each
// input word is a request: a sample tick (tuser 0) that carries the line's
// audio control byte, a byte write into the shift register (tuser 1), or an
// interrupt acknowledge (tuser 2); tuser 3 does nothing but still returns a
// word. Every request gives exactly one result word holding the audio sample
// (bit 0 times sixteen times the volume, or zero), whether this request newly
// raised the sound interrupt, the pending flag afterward and the shift register
// contents afterward. The block takes one word per clock cycle unless stalled and
// shows its result in the cycle after acceptance; the rate is set by the single
// register stage holding the accumulator, counter and shift register, updated in
// the same cycle that the request is taken. The result register is refilled
// whenever it is empty or being drained, so input and output stall together only
// when the downstream side holds off. The user must write periods and the
// interrupt enable through the plain configuration port only while no request is
// in flight, unenforced by the block; the interrupt fires every SHIFTS_PER_IRQ shifts.
module sound_shift_register_generator_unit import ssrg_pkg::*; #(
    parameter int unsigned SHIFTS_PER_IRQ = SHIFTS_PER_IRQ_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    // Configuration write port.
    input  logic                      cfg_wr_en,
    input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata,

    // Request stream.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // From bit 0: line_control[7:0], byte_select[9:8], byte_value[17:10], zeros.
    input  logic [S_TDATA_WIDTH-1:0]  s_tdata,
    // From bit 0: req_type[1:0].
    input  logic [S_TUSER_WIDTH-1:0]  s_tuser,

    // Result stream.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // From bit 0: sample_level[7:0], irq_raised[8], irq_pending_now[9],
    // shift_contents[33:10], zeros.
    output logic [M_TDATA_WIDTH-1:0]  m_tdata
);

    ssrg_cfg_t    cfg_reg;
    ssrg_state_t  state_reg;
    ssrg_state_t  state_next;
    ssrg_req_t    req;
    ssrg_result_t result;
    ssrg_result_t result_reg;
    logic         m_tvalid_reg;
    logic         s_accept;

    // The result register can take a new word when it is empty or its
    // current word leaves in this cycle.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign req.req_type     = s_tuser;
    assign req.line_control = s_tdata[7:0];
    assign req.byte_select  = s_tdata[9:8];
    assign req.byte_value   = s_tdata[17:10];

    ssrg_step #(
        .SHIFTS_PER_IRQ(SHIFTS_PER_IRQ)
    ) u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .req        (req),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fast_period <= FAST_PERIOD_RESET;
            cfg_reg.slow_period <= SLOW_PERIOD_RESET;
            cfg_reg.irq_enable  <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_FAST_PERIOD: cfg_reg.fast_period <= cfg_wdata[PERIOD_WIDTH-1:0];
                CFG_SLOW_PERIOD: cfg_reg.slow_period <= cfg_wdata[PERIOD_WIDTH-1:0];
                CFG_IRQ_ENABLE:  cfg_reg.irq_enable  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Generator state advances on every accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b000000, result_reg.shift_contents, result_reg.irq_pending_now,
                       result_reg.irq_raised, result_reg.sample_level};

    // The shift counter restarts before it reaches the interrupt interval.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.shift_count < COUNT_WIDTH'(SHIFTS_PER_IRQ))
        else $error("shift counter ran past the interrupt interval");

    // A newly raised interrupt is always shown as pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && result_reg.irq_raised |-> result_reg.irq_pending_now)
        else $error("raised interrupt not reported as pending");

    // An interrupt is only raised while interrupts are enabled and none is pending.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && result.irq_raised |-> cfg_reg.irq_enable && !state_reg.irq_pending)
        else $error("interrupt raised while disabled or already pending");

    // An acknowledge clears the pending flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser == REQ_ACK |=> !state_reg.irq_pending)
        else $error("acknowledge did not clear the pending interrupt");

endmodule

@@ sv/ssrg_step.sv @@
// Next-state and result logic for one request word.
module ssrg_step import ssrg_pkg::*; #(
    parameter int unsigned SHIFTS_PER_IRQ = SHIFTS_PER_IRQ_DEFAULT
) (
    input  ssrg_state_t  state,
    input  ssrg_cfg_t    cfg,
    input  ssrg_req_t    req,
    output ssrg_state_t  state_next,
    output ssrg_result_t result
);

    logic [PERIOD_WIDTH-1:0] period;
    logic [PHASE_WIDTH-1:0]  phase_inc;
    logic                    do_shift;
    logic                    feedback;
    logic [SHIFT_WIDTH-1:0]  shifted;
    logic [COUNT_WIDTH-1:0]  count_inc;
    logic                    count_wrap;
    logic [7:0]              sample;
    logic                    raised;

    always_comb begin
        period    = req.line_control[CTRL_FAST] ? cfg.fast_period : cfg.slow_period;
        phase_inc = state.phase + ONE_SAMPLE;
        do_shift  = (phase_inc >= {1'b0, period});

        // Tone mode recirculates bit 0; noise mode mixes in the tap and
        // also drops the feedback bit into the middle of the register.
        feedback = state.shift_data[0];
        if (req.line_control[CTRL_NOISE]) begin
            feedback = state.shift_data[0] ^ state.shift_data[NOISE_TAP];
        end
        shifted = state.shift_data >> 1;
        if (req.line_control[CTRL_NOISE]) begin
            shifted[NOISE_DEST] = feedback;
        end
        shifted[SHIFT_WIDTH-1] = feedback;

        count_inc  = state.shift_count + COUNT_WIDTH'(1);
        count_wrap = (count_inc >= COUNT_WIDTH'(SHIFTS_PER_IRQ));

        sample = 8'd0;
        raised = 1'b0;
        state_next = state;

        case (req.req_type)
            REQ_TICK: begin
                if (req.line_control[CTRL_ENABLE] && state.shift_data[0]) begin
                    sample = {req.line_control[3:0], 4'b0000};
                end
                state_next.phase = phase_inc;
                if (do_shift) begin
                    state_next.phase      = phase_inc - {1'b0, period};
                    state_next.shift_data = shifted;
                    state_next.shift_count = count_inc;
                    if (count_wrap) begin
                        state_next.shift_count = '0;
                        if (cfg.irq_enable && !state.irq_pending) begin
                            state_next.irq_pending = 1'b1;
                            raised = 1'b1;
                        end
                    end
                end
            end
            REQ_WRITE: begin
                case (req.byte_select)
                    SEL_BYTE0: state_next.shift_data[7:0]   = req.byte_value;
                    SEL_BYTE1: state_next.shift_data[15:8]  = req.byte_value;
                    SEL_BYTE2: state_next.shift_data[23:16] = req.byte_value;
                    default: ;
                endcase
            end
            REQ_ACK: begin
                state_next.irq_pending = 1'b0;
            end
            default: ;
        endcase

        result.sample_level    = sample;
        result.irq_raised      = raised;
        result.irq_pending_now = state_next.irq_pending;
        result.shift_contents  = state_next.shift_data;
    end

endmodule

@@ bench/sound_shift_register_generator_unit_tb.sv @@
// Self-checking testbench for the sound shift register generator: directed table, then random phases.
module sound_shift_register_generator_unit_tb;
    import ssrg_pkg::*;

    // Request kind 3 is a no-op, and byte position 3 selects nothing.
    localparam logic [1:0] REQ_NOP  = 2'd3;
    localparam logic [1:0] SEL_NONE = 2'd3;

    localparam int unsigned SHIFTS_PER_IRQ  = SHIFTS_PER_IRQ_DEFAULT;
    localparam int unsigned ITEMS_PER_PHASE = 305;
    localparam int unsigned NUM_PHASES      = 5;
    localparam int unsigned HOLD_CYCLES     = 80;
    localparam int unsigned HOLD_AFTER      = 100;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned CYCLE_LIMIT     = 200000;

    // One row of the directed table. When "typed" is set, the expected result is
    // written in the row; otherwise the row is checked against the predictor.
    typedef struct packed {
        logic [1:0]  req;
        logic [7:0]  ctrl;
        logic [1:0]  sel;
        logic [7:0]  val;
        logic        typed;
        logic [7:0]  level;
        logic        raised;
        logic        pend;
        logic [23:0] bits;
    } stim_row_t;

    localparam int unsigned NUM_ROWS = 26;

    // The first part walks through every request kind and both byte extremes
    // from reset. Default periods are about 16 and 64 samples, so the first
    // thirteen rows never shift and their results can be written out by hand.
    // The last tick is the seventeenth and is the first to cross the fast period,
    // with the noise tap active.
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{REQ_TICK,  8'h00, SEL_BYTE0, 8'h00, 1'b1, 8'd0,   1'b0, 1'b0, 24'h000000},
        '{REQ_WRITE, 8'h00, SEL_BYTE0, 8'hFF, 1'b1, 8'd0,   1'b0, 1'b0, 24'h0000FF},
        '{REQ_WRITE, 8'h00, SEL_BYTE1, 8'h00, 1'b1, 8'd0,   1'b0, 1'b0, 24'h0000FF},
        '{REQ_WRITE, 8'h00, SEL_BYTE2, 8'hA5, 1'b1, 8'd0,   1'b0, 1'b0, 24'hA500FF},
        '{REQ_WRITE, 8'h00, SEL_NONE,  8'h5A, 1'b1, 8'd0,   1'b0, 1'b0, 24'hA500FF},
        '{REQ_TICK,  8'h8F, SEL_BYTE0, 8'h00, 1'b1, 8'd240, 1'b0, 1'b0, 24'hA500FF},
        '{REQ_TICK,  8'h0F, SEL_BYTE0, 8'h00, 1'b1, 8'd0,   1'b0, 1'b0, 24'hA500FF},
        '{REQ_TICK,  8'hC1, SEL_BYTE0, 8'h00, 1'b1, 8'd16,  1'b0, 1'b0, 24'hA500FF},
        '{REQ_NOP,   8'hFF, SEL_NONE,  8'hFF, 1'b1, 8'd0,   1'b0, 1'b0, 24'hA500FF},
        '{REQ_ACK,   8'h00, SEL_BYTE0, 8'h00, 1'b1, 8'd0,   1'b0, 1'b0, 24'hA500FF},
        '{REQ_WRITE, 8'h00, SEL_BYTE0, 8'h00, 1'b1, 8'd0,   1'b0, 1'b0, 24'hA50000},
        '{REQ_WRITE, 8'h00, SEL_BYTE2, 8'hFF, 1'b1, 8'd0,   1'b0, 1'b0, 24'hFF0000},
        '{REQ_WRITE, 8'h00, SEL_BYTE0, 8'h01, 1'b1, 8'd0,   1'b0, 1'b0, 24'hFF0001},
        '{REQ_TICK,  8'hFF, SEL_BYTE0, 8'h00, 1'b0, 8'd0,   1'b0, 1'b0, 24'h000000},
        '{REQ_TICK,  8'hB7, SEL_BYTE1, 8'h00, 1'b0, 8'd0,   1'b0, 1'b0, 24'h000000},
        '{REQ_TICK,  8'h20, SEL_BYTE0, 8'h00, 1'b0, 8'd0,   1'b0, 1'b0, 24'h000000},
        '{REQ_TICK,  8'h30, SEL_BYTE0, 8'h00, 1'b0, 8'd0,   1'b0, 1'b0, 24'h000000},
        '{REQ_TICK,  8'h90, SEL_BYTE0, 8'h00, 1'b0, 8'd0,   1'b0, 1'b0, 24'h000000},
        '{REQ_TICK,  8'hA8, SEL_BYTE0, 8'h00, 1'b0, 8'd0,   1'b0, 1'b0, 24'h000000},
        '{REQ_TICK,  8'h7F, SEL_BYTE0, 8'h00, 1'b0, 8'd0,   1'b0, 1'b0, 24'h000000},
        '{REQ_TICK,  8'h10, SEL_BYTE0, 8'h00, 1'b0, 8'd0,   1'b0, 1'b0, 24'h000000},
        '{REQ_TICK,  8'hE3, SEL_BYTE2, 8'hFF, 1'b0, 8'd0,   1'b0, 1'b0, 24'h000000},
        '{REQ_TICK,  8'h40, SEL_BYTE0, 8'h00, 1'b0, 8'd0,   1'b0, 1'b0, 24'h000000},
        '{REQ_TICK,  8'h8A, SEL_BYTE0, 8'h00, 1'b0, 8'd0,   1'b0, 1'b0, 24'h000000},
        '{REQ_TICK,  8'hB5, SEL_BYTE0, 8'h00, 1'b0, 8'd0,   1'b0, 1'b0, 24'h000000},
        '{REQ_TICK,  8'hFF, SEL_BYTE0, 8'h00, 1'b0, 8'd0,   1'b0, 1'b0, 24'h000000}
    };

    logic                      aclk = 1'b0;
    logic                      aresetn;
    logic                      cfg_wr_en;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr;
    logic [CFG_DATA_WIDTH-1:0] cfg_wdata;
    logic                      s_tvalid;
    logic                      s_tready;
    // From bit 0: line_control[7:0], byte_select[9:8], byte_value[17:10], zeros.
    logic [S_TDATA_WIDTH-1:0]  s_tdata;
    // From bit 0: req_type[1:0].
    logic [S_TUSER_WIDTH-1:0]  s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    // From bit 0: sample_level[7:0], irq_raised[8], irq_pending_now[9],
    // shift_contents[33:10], zeros.
    logic [M_TDATA_WIDTH-1:0]  m_tdata;

    // Predictor state and its copy of the configuration registers.
    logic [SHIFT_WIDTH-1:0]  reg_bits;
    logic [PHASE_WIDTH-1:0]  phase_acc;
    logic [COUNT_WIDTH-1:0]  shifts_since_irq;
    logic                    irq_flag;
    logic [PERIOD_WIDTH-1:0] fast_period;
    logic [PERIOD_WIDTH-1:0] slow_period;
    logic                    irq_allowed;

    // Result words still owed by the block, oldest first.
    ssrg_result_t sound_expected [$];

    int unsigned mismatches;
    int unsigned results_checked;
    int unsigned words_sent;
    int unsigned shift_moves;
    int unsigned irq_raises;
    int unsigned cycle_count;
    bit          calm;
    bit          long_hold_done;

    sound_shift_register_generator_unit #(
        .SHIFTS_PER_IRQ (SHIFTS_PER_IRQ)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Advances the predicted block by one request and returns the word it owes.
    // A tick samples bit 0 before anything moves, then adds one sample to the
    // accumulator; crossing the selected period costs one period and one shift.
    // With a period under one sample the accumulator simply keeps climbing and
    // wraps, which the 25-bit arithmetic here does on its own.
    function automatic ssrg_result_t predict_sound(input ssrg_req_t w);
        ssrg_result_t            r;
        logic [PERIOD_WIDTH-1:0] period;
        logic [SHIFT_WIDTH-1:0]  pre;
        logic                    feedback;
        r = '0;
        case (w.req_type)
            REQ_TICK: begin
                period = w.line_control[CTRL_FAST] ? fast_period : slow_period;
                if (w.line_control[CTRL_ENABLE] && reg_bits[0]) begin
                    r.sample_level = {w.line_control[3:0], 4'b0000};
                end
                phase_acc = phase_acc + ONE_SAMPLE;
                if (phase_acc >= {1'b0, period}) begin
                    phase_acc = phase_acc - {1'b0, period};
                    pre       = reg_bits;
                    feedback  = pre[0];
                    reg_bits  = pre >> 1;
                    // Noise mode mixes in the tap and also drops the bit into the
                    // middle of the register, which shortens the sequence.
                    if (w.line_control[CTRL_NOISE]) begin
                        feedback = feedback ^ pre[NOISE_TAP];
                        reg_bits[NOISE_DEST] = feedback;
                    end
                    reg_bits[SHIFT_WIDTH-1] = feedback;
                    shift_moves++;
                    shifts_since_irq = shifts_since_irq + 1'b1;
                    // The count restarts even when no interrupt can be raised.
                    if (shifts_since_irq >= SHIFTS_PER_IRQ) begin
                        shifts_since_irq = '0;
                        if (irq_allowed && !irq_flag) begin
                            irq_flag     = 1'b1;
                            r.irq_raised = 1'b1;
                            irq_raises++;
                        end
                    end
                end
            end
            REQ_WRITE: begin
                case (w.byte_select)
                    SEL_BYTE0: reg_bits[7:0]   = w.byte_value;
                    SEL_BYTE1: reg_bits[15:8]  = w.byte_value;
                    SEL_BYTE2: reg_bits[23:16] = w.byte_value;
                    default: ;
                endcase
            end
            REQ_ACK: begin
                irq_flag = 1'b0;
            end
            default: ;
        endcase
        r.irq_pending_now = irq_flag;
        r.shift_contents  = reg_bits;
        return r;
    endfunction

    // Mostly ticks, so the accumulator and the interrupt count get somewhere,
    // with enough writes and acknowledges to keep the register and flag moving.
    function automatic ssrg_req_t random_word();
        ssrg_req_t   w;
        int unsigned pick;
        pick           = $urandom_range(0, 19);
        w.line_control = 8'($urandom_range(0, 255));
        w.byte_select  = 2'($urandom_range(0, 3));
        w.byte_value   = 8'($urandom_range(0, 255));
        if (pick < 14) begin
            w.req_type = REQ_TICK;
        end else if (pick < 17) begin
            w.req_type = REQ_WRITE;
        end else if (pick < 19) begin
            w.req_type = REQ_ACK;
        end else begin
            w.req_type = REQ_NOP;
        end
        return w;
    endfunction

    function automatic void note_mismatch(input string field, input logic [23:0] want,
                                          input logic [23:0] got);
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
        mismatches++;
    endfunction

    // Writes all three registers on back-to-back cycles. Called at a falling
    // edge with no request in flight; returns at a falling edge.
    task automatic load_settings(input logic [23:0] fast, input logic [23:0] slow,
                                 input logic [23:0] enable_word);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_FAST_PERIOD;
        cfg_wdata <= fast;
        @(negedge aclk);
        cfg_addr  <= CFG_SLOW_PERIOD;
        cfg_wdata <= slow;
        @(negedge aclk);
        cfg_addr  <= CFG_IRQ_ENABLE;
        cfg_wdata <= enable_word;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        fast_period = fast;
        slow_period = slow;
        irq_allowed = enable_word[0];
    endtask

    // Offers one request word, possibly after a random gap, and records the
    // result it owes once the block takes it. Called and returns at a falling edge.
    task automatic push_word(input ssrg_req_t w, input logic typed, input ssrg_result_t want);
        ssrg_result_t guess;
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.req_type;
        s_tdata  <= {6'b000000, w.byte_value, w.byte_select, w.line_control};
        do @(posedge aclk); while (!s_tready);
        guess = predict_sound(w);
        sound_expected.push_back(typed ? want : guess);
        words_sent++;
        @(negedge aclk);
    endtask

    // Result side. Outside the final phase it stalls in random bursts, and once,
    // early in the first random phase, it holds off long enough for the block to
    // fill up and push back on the request side.
    initial begin
        int unsigned held;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!long_hold_done && results_checked >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(negedge aclk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Every accepted result word is held against the oldest outstanding one.
    always @(posedge aclk) begin
        ssrg_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (sound_expected.size() == 0) begin
                $display("%0t: result word 0x%0h arrived, expected none", $time, m_tdata);
                mismatches++;
            end else begin
                want = sound_expected.pop_front();
                if (m_tdata[7:0] !== want.sample_level)
                    note_mismatch("sample_level", 24'(want.sample_level), 24'(m_tdata[7:0]));
                if (m_tdata[8] !== want.irq_raised)
                    note_mismatch("irq_raised", 24'(want.irq_raised), 24'(m_tdata[8]));
                if (m_tdata[9] !== want.irq_pending_now)
                    note_mismatch("irq_pending_now", 24'(want.irq_pending_now),
                                  24'(m_tdata[9]));
                if (m_tdata[33:10] !== want.shift_contents)
                    note_mismatch("shift_contents", want.shift_contents, m_tdata[33:10]);
                results_checked++;
            end
        end
    end

    // Watchdog: a run that has not ended by now is hung somewhere.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: no finish after %0d cycles, %0d words still owed", $time,
                 CYCLE_LIMIT, sound_expected.size());
        $display("** sound_shift_register_generator_unit: FAILED **");
        $finish;
    end

    initial begin
        ssrg_req_t    w;
        ssrg_result_t want;
        int unsigned  phase;
        mismatches       = 0;
        results_checked  = 0;
        words_sent       = 0;
        shift_moves      = 0;
        irq_raises       = 0;
        calm             = 1'b0;
        long_hold_done   = 1'b0;
        reg_bits         = '0;
        phase_acc        = '0;
        shifts_since_irq = '0;
        irq_flag         = 1'b0;
        fast_period      = FAST_PERIOD_RESET;
        slow_period      = SLOW_PERIOD_RESET;
        irq_allowed      = 1'b0;
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_addr         = CFG_FAST_PERIOD;
        cfg_wdata        = '0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = REQ_TICK;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table under the reset configuration.
        foreach (directed_rows[i]) begin
            w    = '{req_type: directed_rows[i].req, line_control: directed_rows[i].ctrl,
                     byte_select: directed_rows[i].sel, byte_value: directed_rows[i].val};
            want = '{sample_level: directed_rows[i].level,
                     irq_raised: directed_rows[i].raised,
                     irq_pending_now: directed_rows[i].pend,
                     shift_contents: directed_rows[i].bits};
            push_word(w, directed_rows[i].typed, want);
        end

        // Random phases, each under its own register setting. Registers only
        // change once every owed word is back, since each request yields one.
        //   1: fastest legal fast period, slowest slow period, interrupts on
        //   2: periods under one sample, so every tick shifts and the
        //      accumulator wraps; the enable word has all bits set
        //   3: the reverse extremes, interrupts off by an even enable word
        //   4: random moderate periods and a random enable
        //   5: random periods, interrupts on, and no idling on either side
        for (phase = 1; phase <= NUM_PHASES; phase++) begin
            s_tvalid <= 1'b0;
            while (sound_expected.size() != 0) @(posedge aclk);
            if (phase == NUM_PHASES) calm = 1'b1;
            @(negedge aclk);
            case (phase)
                1: load_settings(24'd65536, 24'hFFFFFF, 24'd1);
                2: load_settings(24'd0, 24'd1, 24'hFFFFFF);
                3: load_settings(24'hFFFFFF, 24'd65536, 24'hFFFFFE);
                4: load_settings(24'($urandom_range(65536, 400000)),
                                 24'($urandom_range(65536, 400000)),
                                 24'($urandom_range(0, 1)));
                default: load_settings(24'($urandom_range(65536, 200000)),
                                       24'($urandom_range(0, 24'hFFFFFF)), 24'd1);
            endcase
            repeat (ITEMS_PER_PHASE) push_word(random_word(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (sound_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d request words and checked %0d results; the register shifted %0d times",
                 words_sent, results_checked, shift_moves);
        $display("and raised %0d interrupts over %0d period settings, %s",
                 irq_raises, NUM_PHASES + 1, "one long output stall included.");
        if (mismatches == 0 && sound_expected.size() == 0) begin
            $display("** sound_shift_register_generator_unit: PASSED **");
        end else begin
            $display("** sound_shift_register_generator_unit: FAILED **");
        end
        $finish;
    end

endmodule

@@ sound_shift_register_generator_unit.f @@
sv/ssrg_pkg.sv
sv/ssrg_step.sv
sv/sound_shift_register_generator_unit.sv
bench/sound_shift_register_generator_unit_tb.sv
